>>> rtl/hierarchical_timer_wheel_assert.svh
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_assert
// Assertion macros for the timer wheel; empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_TIMER_WHEEL_ASSERT_SVH
`define HIERARCHICAL_TIMER_WHEEL_ASSERT_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define HTW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("timer wheel assertion failed");
// expression must never be true outside reset
`define HTW_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("timer wheel forbidden condition");
`else
`define HTW_ASSERT(lbl, prop)
`define HTW_NEVER(lbl, expr)
`endif

`endif

>>> rtl/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Shared codes and state encoding of the hierarchical timer wheel
// ----------------------------------------------------------------------------
package htw_pkg;

  // request codes
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_START  = 2'd1,
    MODE_CANCEL = 2'd2
  } mode_e;

  // result codes
  typedef enum logic [2:0] {
    KIND_STARTED   = 3'd0,
    KIND_EXPIRED   = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_POOL_FULL = 3'd4,
    KIND_TICK_DONE = 3'd5
  } kind_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_CAN_RD,
    ST_CAN_EX,
    ST_NOT_FOUND,
    ST_L0_RD,
    ST_L0_EX,
    ST_CAS_RD,
    ST_CAS_EX,
    ST_EM_RD,
    ST_EM_EX,
    ST_DONE
  } state_e;

endpackage

>>> rtl/htw_ram.sv
// ----------------------------------------------------------------------------
// htw_ram
// Generic single write port, single read port RAM with registered read
// ----------------------------------------------------------------------------
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/hierarchical_timer_wheel.sv
// Start: the start state writes the slot once the output is free; cancel: a read and a check
// state per slot searched, plus a not-found state when the id is absent.
// Tick: a level-0 pass over the pool, one more pass per cascaded level, an expiry pass,
// then tick done; output stalls lengthen the expiry pass and the tick-done step.
// Throughput: one transaction at a time; the slot record RAM read port sets the pace.
// Reset: control, time, spoke indices, id counter and slot valid bits cleared;
// the slot record RAM is not initialized and needs no clearing pass.
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel
// Multi-level timing wheel over a fixed timer pool, one slot per step
// ----------------------------------------------------------------------------
`include "hierarchical_timer_wheel_assert.svh"

module hierarchical_timer_wheel import htw_pkg::*; #(
  parameter int LEVELS      = 5,
  parameter int LEVEL0_BITS = 8,
  parameter int UPPER_BITS  = 6,
  parameter int POOL_SIZE   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] interval_ticks_i,
  input  logic        periodic_i,
  input  logic [31:0] cancel_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] timer_id_o,
  output logic        last_o
);

  localparam int LVW = $clog2(LEVELS);
  localparam int SPW = (LEVEL0_BITS > UPPER_BITS) ? LEVEL0_BITS : UPPER_BITS;
  localparam int AW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [SPW-1:0] MASK0_S = SPW'((1 << LEVEL0_BITS) - 1);
  localparam logic [SPW-1:0] MASKU_S = SPW'((1 << UPPER_BITS) - 1);
  localparam logic [AW-1:0]  LAST_IDX = AW'(POOL_SIZE - 1);
  localparam logic [LVW-1:0] TOP_LVL  = LVW'(LEVELS - 1);

  typedef struct packed {
    logic [31:0]    id;
    logic [63:0]    deadline;
    logic [31:0]    interval;
    logic           periodic;
    logic [LVW-1:0] level;
    logic [SPW-1:0] spoke;
  } slot_t;

  localparam int RW = $bits(slot_t);

  state_e state_q, state_d;
  logic [63:0]    now_q, now_d;
  logic [31:0]    next_id_q, next_id_d;
  logic [SPW-1:0] spoke_q [LEVELS];
  logic [SPW-1:0] spoke_d [LEVELS];
  logic [POOL_SIZE-1:0] valid_q, valid_d;
  logic [POOL_SIZE-1:0] ready_q, ready_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic [SPW-1:0] cur_sp_q, cur_sp_d;
  logic [31:0]    interval_q, interval_d;
  logic           periodic_q, periodic_d;
  logic [31:0]    cancel_q, cancel_d;

  logic        out_valid_q, out_valid_d;
  kind_e       out_kind_q, out_kind_d;
  logic [31:0] out_id_q, out_id_d;
  logic        out_last_q, out_last_d;
  logic        out_free;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_rdata;
  slot_t         rd, wr;

  logic          free_found;
  logic [AW-1:0] free_idx;

  logic [31:0]          pl_v;
  logic [63:0]          pl_v64;
  logic [63:0]          pl_shv;
  logic [LEVEL0_BITS-1:0] pl_l0sum;
  logic [LVW-1:0]       pl_level;
  logic [SPW-1:0]       pl_spoke;

  logic           nxt_cas;
  logic [LVW-1:0] nxt_lvl;

  // slot record store
  htw_ram #(
    .WIDTH (RW),
    .DEPTH (POOL_SIZE),
    .AW    (AW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd = slot_t'(ram_rdata);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (!free_found && !valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  // placement interval source
  always_comb begin
    case (state_q)
      ST_CAS_EX: pl_v = 32'(rd.deadline - now_q);
      ST_START:  pl_v = interval_q;
      default:   pl_v = rd.interval;
    endcase
  end

  assign pl_v64 = {32'b0, pl_v};

  // level and spoke placement
  always_comb begin
    pl_level = TOP_LVL;
    pl_spoke = '0;
    pl_shv   = '0;
    pl_l0sum = '0;
    for (int k = LEVELS - 1; k >= 1; k--) begin
      if (pl_v64 < (64'd1 << (LEVEL0_BITS + k * UPPER_BITS))) begin
        pl_level = LVW'(k);
      end
    end
    for (int k = 1; k < LEVELS; k++) begin
      if (pl_level == LVW'(k)) begin
        pl_shv = (pl_v64 >> (LEVEL0_BITS + (k - 1) * UPPER_BITS))
               + {{(64 - SPW){1'b0}}, spoke_q[k]} - 64'd1;
        pl_spoke = SPW'(pl_shv[UPPER_BITS-1:0]);
      end
    end
    if (pl_v64 < (64'd1 << LEVEL0_BITS)) begin
      pl_level = '0;
      pl_l0sum = pl_v[LEVEL0_BITS-1:0] + spoke_q[0][LEVEL0_BITS-1:0];
      pl_spoke = SPW'(pl_l0sum);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer next state and datapath control
  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    next_id_d   = next_id_q;
    spoke_d     = spoke_q;
    valid_d     = valid_q;
    ready_d     = ready_q;
    idx_d       = idx_q;
    lvl_d       = lvl_q;
    cur_sp_d    = cur_sp_q;
    interval_d  = interval_q;
    periodic_d  = periodic_q;
    cancel_d    = cancel_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    wr          = rd;
    nxt_cas     = 1'b0;
    nxt_lvl     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          interval_d = interval_ticks_i;
          periodic_d = periodic_i;
          cancel_d   = cancel_id_i;
          idx_d      = '0;
          case (mode_i)
            MODE_TICK: begin
              now_d   = now_q + 64'd1;
              ready_d = '0;
              state_d = ST_L0_RD;
            end
            MODE_START:  state_d = ST_START;
            MODE_CANCEL: state_d = ST_CAN_RD;
            default:     state_d = ST_IDLE;
          endcase
        end
      end

      ST_START: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (!free_found) begin
            out_kind_d = KIND_POOL_FULL;
            out_id_d   = '0;
          end else begin
            ram_we      = 1'b1;
            ram_waddr   = free_idx;
            wr.id       = next_id_q;
            wr.deadline = now_q + {32'b0, interval_q};
            wr.interval = interval_q;
            wr.periodic = periodic_q;
            wr.level    = pl_level;
            wr.spoke    = pl_spoke;
            valid_d[free_idx] = 1'b1;
            next_id_d  = next_id_q + 32'd1;
            out_kind_d = KIND_STARTED;
            out_id_d   = next_id_q;
          end
          state_d = ST_IDLE;
        end
      end

      ST_CAN_RD: state_d = ST_CAN_EX;

      ST_CAN_EX: begin
        if (valid_q[idx_q] && rd.id == cancel_q) begin
          if (out_free) begin
            valid_d[idx_q] = 1'b0;
            out_valid_d = 1'b1;
            out_kind_d  = KIND_CANCELLED;
            out_id_d    = cancel_q;
            out_last_d  = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (idx_q == LAST_IDX) begin
          state_d = ST_NOT_FOUND;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CAN_RD;
        end
      end

      ST_NOT_FOUND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_NOT_FOUND;
          out_id_d    = cancel_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_L0_RD: state_d = ST_L0_EX;

      ST_L0_EX: begin
        if (valid_q[idx_q] && rd.level == '0 && rd.spoke == spoke_q[0]) begin
          ready_d[idx_q] = 1'b1;
        end
        if (idx_q == LAST_IDX) begin
          idx_d = '0;
          if (spoke_q[0] == MASK0_S) begin
            spoke_d[0] = '0;
            nxt_cas    = 1'b1;
            nxt_lvl    = LVW'(1);
          end else begin
            spoke_d[0] = spoke_q[0] + 1'b1;
            state_d    = ST_EM_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_L0_RD;
        end
      end

      ST_CAS_RD: state_d = ST_CAS_EX;

      ST_CAS_EX: begin
        if (valid_q[idx_q] && !ready_q[idx_q] && rd.level == lvl_q &&
            rd.spoke == cur_sp_q) begin
          if (rd.deadline <= now_q) begin
            ready_d[idx_q] = 1'b1;
          end else begin
            ram_we   = 1'b1;
            wr.level = pl_level;
            wr.spoke = pl_spoke;
          end
        end
        if (idx_q == LAST_IDX) begin
          idx_d = '0;
          if (cur_sp_q == MASKU_S && lvl_q != TOP_LVL) begin
            nxt_cas = 1'b1;
            nxt_lvl = lvl_q + 1'b1;
          end else begin
            state_d = ST_EM_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CAS_RD;
        end
      end

      ST_EM_RD: state_d = ST_EM_EX;

      ST_EM_EX: begin
        if (!ready_q[idx_q] || out_free) begin
          if (ready_q[idx_q]) begin
            ready_d[idx_q] = 1'b0;
            out_valid_d = 1'b1;
            out_kind_d  = KIND_EXPIRED;
            out_id_d    = rd.id;
            out_last_d  = 1'b0;
            if (rd.periodic) begin
              ram_we      = 1'b1;
              wr.deadline = now_q + {32'b0, rd.interval};
              wr.level    = pl_level;
              wr.spoke    = pl_spoke;
            end else begin
              valid_d[idx_q] = 1'b0;
            end
          end
          if (idx_q == LAST_IDX) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_EM_RD;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_TICK_DONE;
          out_id_d    = '0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // start a cascade pass: latch the spoke to drain and advance its index
    if (nxt_cas) begin
      lvl_d   = nxt_lvl;
      state_d = ST_CAS_RD;
      for (int k = 1; k < LEVELS; k++) begin
        if (nxt_lvl == LVW'(k)) begin
          cur_sp_d   = spoke_q[k];
          spoke_d[k] = (spoke_q[k] == MASKU_S) ? '0 : spoke_q[k] + 1'b1;
        end
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      next_id_q   <= '0;
      valid_q     <= '0;
      ready_q     <= '0;
      idx_q       <= '0;
      lvl_q       <= '0;
      cur_sp_q    <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < LEVELS; k++) begin
        spoke_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      next_id_q   <= next_id_d;
      valid_q     <= valid_d;
      ready_q     <= ready_d;
      idx_q       <= idx_d;
      lvl_q       <= lvl_d;
      cur_sp_q    <= cur_sp_d;
      out_valid_q <= out_valid_d;
      spoke_q     <= spoke_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    interval_q <= interval_d;
    periodic_q <= periodic_d;
    cancel_q   <= cancel_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign timer_id_o  = out_id_q;
  assign last_o      = out_last_q;

  // checks
  `HTW_ASSERT(a_done_is_last, (out_valid_o && kind_o == KIND_TICK_DONE) |-> last_o)
  `HTW_ASSERT(a_id_on_start, !$stable(next_id_q) |-> (out_valid_o && kind_o == KIND_STARTED))
  `HTW_NEVER(a_expired_last, out_valid_o && kind_o == KIND_EXPIRED && last_o)

endmodule
